// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue with counts.
// No dependencies.
package spq_pkg;

  localparam int unsigned DepthDef = 64;
  localparam int unsigned CntW     = 7;
  localparam logic [CntW-1:0] CntMax = 7'd127;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_REM_EV,
    S_CNT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] ident;
    logic [15:0] ktime;
  } entry_t;

endpackage

// File: rtl/sorted_priority_queue_with_counts.sv
`timescale 1ns / 1ps
// Insert walks back from the tail, shifting each stored entry whose key is at or after the
// new key up one slot, then places it; remove reads the head entry. Every operation then
// counts over the stored entries of the single-port-read entry memory and loads the
// output register. One item at a time: in_stall_o stays high until the output register
// takes the result, which waits while out_stall_i holds a previous result.
// Reset: occupancy and head pointer clear; memory contents stay undefined.
module sorted_priority_queue_with_counts
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  tag_i,
  input  logic [15:0] ident_i,
  input  logic [15:0] key_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_tag_o,
  output logic [15:0] out_ident_o,
  output logic [15:0] out_time_o,
  output logic [6:0]  occupancy_o,
  output logic [6:0]  tag_matches_o,
  output logic [6:0]  ident_smaller_o,
  output logic [6:0]  ident_larger_o,
  output logic [6:0]  time_earlier_o,
  output logic [6:0]  time_later_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DepthW = (CW + 1)'(DEPTH);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rv_q, rv_d;
  logic [1:0]    op_q, op_d;
  entry_t        in_q, in_d;
  status_e       stat_q, stat_d;
  entry_t        rem_q, rem_d;
  logic [CntW-1:0] n_tag_q, n_tag_d, n_sm_q, n_sm_d, n_lg_q, n_lg_d;
  logic [CntW-1:0] n_er_q, n_er_d, n_lt_q, n_lt_d;

  logic          ov_q, ov_d;
  status_e       o_stat_q, o_stat_d;
  entry_t        o_rem_q, o_rem_d;
  logic [CntW-1:0] o_occ_q, o_occ_d, o_tag_q, o_tag_d, o_sm_q, o_sm_d;
  logic [CntW-1:0] o_lg_q, o_lg_d, o_er_q, o_er_d, o_lt_q, o_lt_d;

  entry_t        mem [DEPTH];
  entry_t        rd_data_q;
  logic          rd_en, we;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;
  logic          accept;
  logic [CW+6:0] occ_ext;

  // logical slot to physical address on the ring
  function automatic logic [AW-1:0] phys(logic [AW-1:0] head, logic [CW-1:0] lidx);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(lidx);
    if (sum >= DepthW) sum = sum - DepthW;
    return sum[AW-1:0];
  endfunction

  function automatic logic [CntW-1:0] inc_sat(logic [CntW-1:0] v, logic hit);
    return (hit && v != CntMax) ? v + 1'b1 : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  assign accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign occ_ext = (CW + 7)'(count_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    head_d  = head_q;
    idx_d   = idx_q;
    rv_d    = 1'b0;
    op_d    = op_q;
    in_d    = in_q;
    stat_d  = stat_q;
    rem_d   = rem_q;
    n_tag_d = n_tag_q;
    n_sm_d  = n_sm_q;
    n_lg_d  = n_lg_q;
    n_er_d  = n_er_q;
    n_lt_d  = n_lt_q;
    ov_d     = ov_q && out_stall_i;
    o_stat_d = o_stat_q;
    o_rem_d  = o_rem_q;
    o_occ_d  = o_occ_q;
    o_tag_d  = o_tag_q;
    o_sm_d   = o_sm_q;
    o_lg_d   = o_lg_q;
    o_er_d   = o_er_q;
    o_lt_d   = o_lt_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = '0;
    wr_data = in_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_i;
          in_d    = '{tag: tag_i, ident: ident_i, ktime: key_time_i};
          stat_d  = ST_OK;
          rem_d   = '0;
          idx_d   = '0;
          n_tag_d = '0;
          n_sm_d  = '0;
          n_lg_d  = '0;
          n_er_d  = '0;
          n_lt_d  = '0;
          state_d = S_CNT;
          unique case (op_e'(op_i))
            OP_INSERT: begin
              if (ident_i == '0 || key_time_i == '0) begin
                stat_d = ST_INVALID;
              end else if ((CW + 1)'(count_q) == DepthW) begin
                stat_d = ST_FULL;
              end else begin
                idx_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                stat_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = S_REM_EV;
              end
            end
            OP_QUERY, OP_SPARE: ;
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        // idx_q is the free slot; look at the entry just before it
        if (idx_q == '0) begin
          we      = 1'b1;
          wr_addr = head_q;
          count_d = count_q + 1'b1;
          state_d = S_CNT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(head_q, idx_q - 1'b1);
          state_d = S_INS_EV;
        end
      end
      S_INS_EV: begin
        we      = 1'b1;
        wr_addr = phys(head_q, idx_q);
        if (rd_data_q.ktime >= in_q.ktime) begin
          wr_data = rd_data_q;
          idx_d   = idx_q - 1'b1;
          state_d = S_INS_RD;
        end else begin
          count_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = S_CNT;
        end
      end
      S_REM_EV: begin
        rem_d   = rd_data_q;
        head_d  = (32'(head_q) == DEPTH - 1) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
        state_d = S_CNT;
      end
      S_CNT: begin
        if (idx_q != count_q) begin
          rd_en   = 1'b1;
          rd_addr = phys(head_q, idx_q);
          idx_d   = idx_q + 1'b1;
          rv_d    = 1'b1;
        end else if (!rv_q) begin
          state_d = S_DONE;
        end
        if (rv_q) begin
          n_tag_d = inc_sat(n_tag_q, rd_data_q.tag == in_q.tag);
          n_sm_d  = inc_sat(n_sm_q, rd_data_q.ident < in_q.ident);
          n_lg_d  = inc_sat(n_lg_q, rd_data_q.ident > in_q.ident);
          n_er_d  = inc_sat(n_er_q, rd_data_q.ktime < in_q.ktime);
          n_lt_d  = inc_sat(n_lt_q, rd_data_q.ktime > in_q.ktime);
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (!ov_q || !out_stall_i) begin
          ov_d     = 1'b1;
          o_stat_d = stat_q;
          o_rem_d  = rem_q;
          o_occ_d  = (occ_ext > (CW + 7)'(CntMax)) ? CntMax : occ_ext[CntW-1:0];
          o_tag_d  = n_tag_q;
          o_sm_d   = n_sm_q;
          o_lg_d   = n_lg_q;
          o_er_d   = n_er_q;
          o_lt_d   = n_lt_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      idx_q   <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    in_q     <= in_d;
    stat_q   <= stat_d;
    rem_q    <= rem_d;
    n_tag_q  <= n_tag_d;
    n_sm_q   <= n_sm_d;
    n_lg_q   <= n_lg_d;
    n_er_q   <= n_er_d;
    n_lt_q   <= n_lt_d;
    o_stat_q <= o_stat_d;
    o_rem_q  <= o_rem_d;
    o_occ_q  <= o_occ_d;
    o_tag_q  <= o_tag_d;
    o_sm_q   <= o_sm_d;
    o_lg_q   <= o_lg_d;
    o_er_q   <= o_er_d;
    o_lt_q   <= o_lt_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = o_stat_q;
  assign out_tag_o       = o_rem_q.tag;
  assign out_ident_o     = o_rem_q.ident;
  assign out_time_o      = o_rem_q.ktime;
  assign occupancy_o     = o_occ_q;
  assign tag_matches_o   = o_tag_q;
  assign ident_smaller_o = o_sm_q;
  assign ident_larger_o  = o_lg_q;
  assign time_earlier_o  = o_er_q;
  assign time_later_o    = o_lt_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW + 1)'(count_q) <= DepthW) else $error("occupancy beyond depth");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CNT |-> idx_q <= count_q) else $error("count walk overran");
  a_write_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_INS_RD || state_q == S_INS_EV) && op_q == OP_INSERT)
    else $error("memory write outside insert");
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < DEPTH) else $error("head pointer out of range");
`endif

endmodule

// File: tb/sv/tb_sorted_priority_queue_with_counts.sv
`timescale 1ns / 1ps
// Self-checking bench for the sorted priority queue with counts: an in-bench queue
// model predicts every result and a scoreboard class compares them. Depends on spq_pkg.
module tb_sorted_priority_queue_with_counts;
  import spq_pkg::*;

  localparam int unsigned Depth = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tag;
    logic [15:0] ident;
    logic [15:0] ktime;
    logic [6:0]  occ;
    logic [6:0]  n_tag;
    logic [6:0]  n_small;
    logic [6:0]  n_large;
    logic [6:0]  n_early;
    logic [6:0]  n_late;
  } qresult_t;

  int unsigned err_cnt = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  class queue_scoreboard;
    entry_t   slots[$];
    qresult_t pending[$];
    int unsigned n_checked = 0;

    function void note_op(op_e op, logic [7:0] tag, logic [15:0] id, logic [15:0] kt);
      qresult_t r;
      int pos;
      r = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
        if (id == 0 || kt == 0) r.status = ST_INVALID;
        else if (slots.size() >= Depth) r.status = ST_FULL;
        else begin
          pos = 0;
          while (pos < slots.size() && slots[pos].ktime < kt) pos++;
          slots.insert(pos, '{tag: tag, ident: id, ktime: kt});
        end
      end else if (op == OP_REMOVE) begin
        if (slots.size() == 0) r.status = ST_EMPTY;
        else begin
          r.tag = slots[0].tag;
          r.ident = slots[0].ident;
          r.ktime = slots[0].ktime;
          void'(slots.pop_front());
        end
      end
      r.occ = 7'(slots.size());
      foreach (slots[i]) begin
        if (slots[i].tag == tag) r.n_tag++;
        if (slots[i].ident < id) r.n_small++;
        if (slots[i].ident > id) r.n_large++;
        if (slots[i].ktime < kt) r.n_early++;
        if (slots[i].ktime > kt) r.n_late++;
      end
      pending.push_back(r);
    endfunction

    task check_result(qresult_t got);
      qresult_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
        return;
      end
      w = pending.pop_front();
      n_checked++;
      if (got.status  !== w.status)  report_mismatch("status", got.status, w.status);
      if (got.tag     !== w.tag)     report_mismatch("out_tag", got.tag, w.tag);
      if (got.ident   !== w.ident)   report_mismatch("out_ident", got.ident, w.ident);
      if (got.ktime   !== w.ktime)   report_mismatch("out_time", got.ktime, w.ktime);
      if (got.occ     !== w.occ)     report_mismatch("occupancy", got.occ, w.occ);
      if (got.n_tag   !== w.n_tag)   report_mismatch("tag_matches", got.n_tag, w.n_tag);
      if (got.n_small !== w.n_small) report_mismatch("ident_smaller", got.n_small, w.n_small);
      if (got.n_large !== w.n_large) report_mismatch("ident_larger", got.n_large, w.n_large);
      if (got.n_early !== w.n_early) report_mismatch("time_earlier", got.n_early, w.n_early);
      if (got.n_late  !== w.n_late)  report_mismatch("time_later", got.n_late, w.n_late);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [7:0] tag = '0;
  logic [15:0] ident = '0;
  logic [15:0] ktime = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qresult_t res;

  queue_scoreboard sb = new();
  bit quiet = 1'b0;       // no idling in the closing stretch
  bit hold_rx = 1'b0;     // long receiver hold-off requested
  int unsigned n_sent = 0;

  always #10 clk = ~clk;

  sorted_priority_queue_with_counts dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .tag_i(tag), .ident_i(ident), .key_time_i(ktime),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(res.status), .out_tag_o(res.tag), .out_ident_o(res.ident),
    .out_time_o(res.ktime), .occupancy_o(res.occ), .tag_matches_o(res.n_tag),
    .ident_smaller_o(res.n_small), .ident_larger_o(res.n_large),
    .time_earlier_o(res.n_early), .time_later_o(res.n_late)
  );

  // Drive one beat and hold it until accepted; optional idle burst first.
  task automatic send_op(op_e o, logic [7:0] t, logic [15:0] id, logic [15:0] kt);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    tag <= t;
    ident <= id;
    ktime <= kt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(o, t, id, kt);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Random beat: mostly well-formed inserts/removes, some queries and invalid ones.
  task automatic send_random(int unsigned ins_weight);
    int unsigned k;
    logic [15:0] id, kt;
    k = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
    kt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 30));
    if ($urandom_range(0, 30) == 0) id = 0;
    if ($urandom_range(0, 30) == 0) kt = 0;
    if (k < ins_weight) send_op(OP_INSERT, 8'($urandom), id, kt);
    else if (k < 90) send_op(OP_REMOVE, 8'($urandom_range(0, 3)), id, kt);
    else if (k < 97) send_op(OP_QUERY, 8'($urandom_range(0, 3)), id, kt);
    else send_op(OP_SPARE, 8'($urandom), id, kt);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(res);
  end

  initial begin : rx_stall
    int unsigned n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        for (n = 0; n < 3000; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stim
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty remove, invalid inserts, extremes, equal times, spare op.
    send_op(OP_REMOVE, 8'h00, 16'h0000, 16'h0000);
    send_op(OP_INSERT, 8'hff, 16'h0000, 16'h0005);
    send_op(OP_INSERT, 8'hff, 16'h0005, 16'h0000);
    send_op(OP_INSERT, 8'hff, 16'hffff, 16'hffff);
    send_op(OP_INSERT, 8'h00, 16'h0001, 16'h0001);
    send_op(OP_INSERT, 8'haa, 16'h0010, 16'h0100);
    send_op(OP_INSERT, 8'h55, 16'h0020, 16'h0100);
    send_op(OP_QUERY, 8'hff, 16'h0010, 16'h0100);
    send_op(OP_SPARE, 8'h55, 16'hffff, 16'h0000);
    send_op(OP_QUERY, 8'h00, 16'h0000, 16'hffff);
    for (i = 0; i < 6; i++) send_op(OP_REMOVE, 8'haa, 16'h8000, 16'h8000);
    drain();
    // Fill to capacity with the receiver held off, then overflow.
    hold_rx = 1'b1;
    for (i = 0; i < Depth + 3; i++) send_op(OP_INSERT, 8'($urandom),
                                           16'($urandom_range(1, 65535)),
                                           16'($urandom_range(1, 20)));
    drain();
    for (i = 0; i < 350; i++) send_random(70);
    drain();
    for (i = 0; i < 250; i++) send_random(45);
    quiet = 1'b1;
    for (i = 0; i < 80; i++) send_random(50);
    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d beats, checked %0d results incl. full, empty and invalid cases",
             n_sent, sb.n_checked);
    if (err_cnt == 0 && sb.pending.size() == 0) begin
      $display("tb_sorted_priority_queue_with_counts: clean");
    end else begin
      $display("tb_sorted_priority_queue_with_counts: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("tb_sorted_priority_queue_with_counts: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/sorted_priority_queue_with_counts.sv
tb/sv/tb_sorted_priority_queue_with_counts.sv
